@@ rtl/core/spmq_pkg.sv @@
`default_nettype none

package spmq_pkg;

    localparam int NUM_LEVELS  = 3;
    localparam int LEVEL_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;

    localparam int KIND_W     = 2;
    localparam int ITEM_W     = 32;
    localparam int PRI_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 6;

    localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W      = $clog2(LEVEL_DEPTH);
    localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);

    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPRI = 2'd3;

    typedef logic [DATA_WIDTH-1:0] t_data;

    // Store access requested by the control logic for one transaction.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    // Outcome of one transaction, as decided before the store is read.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                read_ok;
        logic [TOTAL_W-1:0]  total;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/spmq_if.sv @@
`default_nettype none

interface spmq_in_if
    import spmq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ITEM_W-1:0]   item;
    logic [PRI_W-1:0]    priority_req;

    modport source (output valid, output kind, output item, output priority_req,
                    input ready);
    modport sink   (input valid, input kind, input item, input priority_req,
                    output ready);
endinterface

interface spmq_out_if
    import spmq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ITEM_W-1:0]   item_out;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total_count;

    modport source (output valid, output item_out, output status, output total_count,
                    input ready);
    modport sink   (input valid, input item_out, input status, input total_count,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/strict_priority_multi_queue.sv @@
// Strict-priority queue with NUM_LEVELS FIFOs of LEVEL_DEPTH words each. Enqueue
// (kind 0) writes to the level given by priority_req, 1..NUM_LEVELS; dequeue (kind 1)
// and peek (kind 2) return the head of the highest non-empty level, dequeue also
// removing it. Every transaction gives exactly one result with a status (ok, empty,
// level full, bad priority) and the total word count after it. The block takes one
// transaction per cycle while not stalled; its result appears in the cycle after
// acceptance, from the registered read of the word store. A stalled result stalls the
// input only while the output register stays full. No clearing pass after reset.
`default_nettype none

module strict_priority_multi_queue
    import spmq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spmq_in_if.sink    i_in,
    spmq_out_if.source o_out
);

    t_mem_req mem_req;
    t_result  result;
    t_data    rd_data;
    logic     accept;

    logic                r_out_valid;
    logic                r_read_ok;
    logic [STATUS_W-1:0] r_status;
    logic [TOTAL_W-1:0]  r_total;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    spmq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_in.kind),
        .i_priority_req (i_in.priority_req),
        .o_mem_req      (mem_req),
        .o_result       (result)
    );

    spmq_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .i_wr_data (i_in.item[DATA_WIDTH-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_ok <= result.read_ok;
            r_status  <= result.status;
            r_total   <= result.total;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.item_out    = r_read_ok ? ITEM_W'(rd_data) : '0;
    assign o_out.status      = r_status;
    assign o_out.total_count = r_total;

`ifndef SYNTH
    // An empty report can only come when nothing is stored.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_EMPTY)) |-> (r_total == '0))
        else $error("empty status with nonzero total");

    // A single transaction never both writes and reads the store.
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.wr_en && mem_req.rd_en))
        else $error("store written and read by one transaction");

    // Only a successful read returns a word.
    a_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_read_ok) |-> (r_status == ST_OK))
        else $error("word returned with failing status");

    // A stalled result keeps its word.
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(o_out.item_out))
        else $error("result word changed while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/core/spmq_store.sv @@
`default_nettype none

module spmq_store
    import spmq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    input  wire t_data    i_wr_data,
    output t_data         o_rd_data
);

    t_data r_mem [STORE_DEPTH];
    t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
    end

    // The read data is only updated by a read, so it holds while the result waits.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/spmq_ctrl.sv @@
`default_nettype none

module spmq_ctrl
    import spmq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [PRI_W-1:0]  i_priority_req,
    output t_mem_req               o_mem_req,
    output t_result                o_result
);

    logic [PTR_W-1:0]   r_head  [NUM_LEVELS];
    logic [PTR_W-1:0]   r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]   r_count [NUM_LEVELS];
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;

    logic              pri_ok;
    logic [LVL_W-1:0]  enq_lvl;
    logic              enq_full;
    logic              top_found;
    logic [LVL_W-1:0]  top_lvl;
    logic              do_enq;
    logic              do_deq;
    logic              do_read;
    logic [PTR_W-1:0]  enq_tail;
    logic [PTR_W-1:0]  top_head;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [PTR_W-1:0] ptr);
        return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(ptr);
    endfunction

    // Highest non-empty level; later levels override earlier ones.
    always_comb begin
        top_found = 1'b0;
        top_lvl   = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_count[i] != '0) begin
                top_found = 1'b1;
                top_lvl   = LVL_W'(i);
            end
        end
    end

    always_comb begin
        pri_ok   = (i_priority_req != '0) && (int'(i_priority_req) <= NUM_LEVELS);
        enq_lvl  = LVL_W'(i_priority_req - PRI_W'(1));
        enq_full = pri_ok && (r_count[enq_lvl] == CNT_W'(LEVEL_DEPTH));
        enq_tail = r_tail[enq_lvl];
        top_head = r_head[top_lvl];

        do_enq  = (i_kind == KIND_ENQ) && pri_ok && !enq_full;
        do_read = ((i_kind == KIND_DEQ) || (i_kind == KIND_PEEK)) && top_found;
        do_deq  = (i_kind == KIND_DEQ) && top_found;

        n_total = r_total;
        if (do_enq) begin
            n_total = r_total + 1'b1;
        end else if (do_deq) begin
            n_total = r_total - 1'b1;
        end

        case (i_kind)
            KIND_ENQ: begin
                if (!pri_ok) begin
                    o_result.status = ST_BADPRI;
                end else if (enq_full) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_result.status = ST_OK;
                end
            end
            KIND_DEQ, KIND_PEEK: begin
                o_result.status = top_found ? ST_OK : ST_EMPTY;
            end
            default: begin
                o_result.status = ST_OK;
            end
        endcase
        o_result.read_ok = do_read;
        o_result.total   = n_total;

        o_mem_req.wr_en   = i_accept && do_enq;
        o_mem_req.wr_addr = store_addr(enq_lvl, enq_tail);
        o_mem_req.rd_en   = i_accept && do_read;
        o_mem_req.rd_addr = store_addr(top_lvl, top_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_total <= '0;
        end else if (i_accept) begin
            if (do_enq) begin
                r_tail[enq_lvl]  <= wrap_next(enq_tail);
                r_count[enq_lvl] <= r_count[enq_lvl] + 1'b1;
            end
            if (do_deq) begin
                r_head[top_lvl]  <= wrap_next(top_head);
                r_count[top_lvl] <= r_count[top_lvl] - 1'b1;
            end
            r_total <= n_total;
        end
    end

endmodule

`default_nettype wire

@@ sim/strict_priority_multi_queue_tb.sv @@
module strict_priority_multi_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spmq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [PRI_W-1:0]  PRI_NONE    = 2'd0;
    localparam int RANDOM_OPS  = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ITEM_W-1:0] item;
        logic [PRI_W-1:0]  pri;
        bit                drain_first;
    } queue_op_t;

    typedef struct {
        logic [ITEM_W-1:0]   item_out;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
    } queue_reply_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spmq_in_if  in_if ();
    spmq_out_if out_if ();

    strict_priority_multi_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    queue_op_t    op_queue[$];
    queue_reply_t reply_queue[$];
    queue_op_t    next_op;
    int           sent_count;
    int           fail_count;
    longint       cycle_count;

    // Shadow copy of the per-level FIFOs.
    logic [DATA_WIDTH-1:0] shadow_words [NUM_LEVELS][LEVEL_DEPTH];
    int                    shadow_head [NUM_LEVELS];
    int                    shadow_tail [NUM_LEVELS];
    int                    shadow_fill [NUM_LEVELS];

    // No idling on either side during one long stretch of the run.
    wire steady = (sent_count >= 500) && (sent_count < 800);

    function automatic queue_reply_t apply_queue_op(input logic [KIND_W-1:0] kind,
                                                    input logic [ITEM_W-1:0] item,
                                                    input logic [PRI_W-1:0]  pri);
        queue_reply_t r;
        int lv;
        int i;
        int sum;
        r.item_out = '0;
        r.status   = ST_OK;
        if (kind == KIND_ENQ) begin
            if (pri == PRI_NONE || pri > NUM_LEVELS) begin
                r.status = ST_BADPRI;
            end else begin
                lv = pri - 1;
                if (shadow_fill[lv] >= LEVEL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[lv][shadow_tail[lv]] = item[DATA_WIDTH-1:0];
                    shadow_tail[lv] = (shadow_tail[lv] + 1) % LEVEL_DEPTH;
                    shadow_fill[lv]++;
                end
            end
        end else if (kind == KIND_DEQ || kind == KIND_PEEK) begin
            lv = -1;
            for (i = NUM_LEVELS - 1; i >= 0 && lv < 0; i--) begin
                if (shadow_fill[i] != 0) lv = i;
            end
            if (lv < 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.item_out = ITEM_W'(shadow_words[lv][shadow_head[lv]]);
                if (kind == KIND_DEQ) begin
                    shadow_head[lv] = (shadow_head[lv] + 1) % LEVEL_DEPTH;
                    shadow_fill[lv]--;
                end
            end
        end
        sum = 0;
        for (i = 0; i < NUM_LEVELS; i++) sum += shadow_fill[i];
        r.total = TOTAL_W'(sum);
        return r;
    endfunction

    task automatic add_op(input logic [KIND_W-1:0] kind, input logic [ITEM_W-1:0] item,
                          input logic [PRI_W-1:0] pri, input bit drain_first);
        queue_op_t op;
        op.kind        = kind;
        op.item        = item;
        op.pri         = pri;
        op.drain_first = drain_first;
        op_queue.insert(op_queue.size(), op);
    endtask

    // Driver: predicts each accepted transaction and presents the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                reply_queue.insert(reply_queue.size(),
                                   apply_queue_op(in_if.kind, in_if.item,
                                                  in_if.priority_req));
                sent_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (op_queue.size() != 0
                    && !(op_queue[0].drain_first && reply_queue.size() != 0)
                    && (steady || $urandom_range(99) >= 30)) begin
                    next_op = op_queue.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.kind         <= next_op.kind;
                    in_if.item         <= next_op.item;
                    in_if.priority_req <= next_op.pri;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (reply_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result: item_out=%h status=%0d total=%0d",
                                 out_if.item_out, out_if.status, out_if.total_count);
                end else if (out_if.item_out !== reply_queue[0].item_out
                             || out_if.status !== reply_queue[0].status
                             || out_if.total_count !== reply_queue[0].total) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"mismatch: expected item_out=%h status=%0d total=%0d, ",
                                  "got item_out=%h status=%0d total=%0d"},
                                 reply_queue[0].item_out, reply_queue[0].status,
                                 reply_queue[0].total, out_if.item_out, out_if.status,
                                 out_if.total_count);
                    void'(reply_queue.pop_front());
                end else begin
                    void'(reply_queue.pop_front());
                end
            end
            out_if.ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("strict_priority_multi_queue_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int n_random;
        int phase;
        int phase_len;
        int mode;
        int favored;
        int enq_pct;
        int k;
        logic [KIND_W-1:0] kind;
        logic [ITEM_W-1:0] item;
        logic [PRI_W-1:0]  pri;

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.kind         = KIND_ENQ;
        in_if.item         = '0;
        in_if.priority_req = PRI_NONE;
        out_if.ready       = 1'b0;
        sent_count         = 0;
        fail_count         = 0;
        cycle_count        = 0;
        for (k = 0; k < NUM_LEVELS; k++) begin
            shadow_head[k] = 0;
            shadow_tail[k] = 0;
            shadow_fill[k] = 0;
        end

        // Empty queue, unused kind and bad priority, then ordering across levels.
        add_op(KIND_DEQ, 32'h1234_5678, 2'd3, 1'b0);
        add_op(KIND_PEEK, 32'hFFFF_FFFF, 2'd1, 1'b0);
        add_op(KIND_UNUSED, 32'hFFFF_FFFF, 2'd3, 1'b0);
        add_op(KIND_ENQ, 32'hFFFF_FFFF, PRI_NONE, 1'b0);
        add_op(KIND_ENQ, 32'h0000_0000, 2'd1, 1'b0);
        add_op(KIND_ENQ, 32'hFFFF_FFFF, 2'd3, 1'b0);
        add_op(KIND_PEEK, 32'h0, PRI_NONE, 1'b0);
        add_op(KIND_DEQ, 32'h0, 2'd2, 1'b0);
        add_op(KIND_DEQ, 32'h0, 2'd1, 1'b0);
        add_op(KIND_DEQ, 32'h0, 2'd1, 1'b0);
        // Fill the middle level past its depth.
        for (k = 0; k <= LEVEL_DEPTH; k++)
            add_op(KIND_ENQ, $urandom, 2'd2, 1'b0);

        n_random = 0;
        phase    = 0;
        while (n_random < RANDOM_OPS) begin
            phase_len = $urandom_range(80, 20);
            mode      = $urandom_range(2);
            favored   = $urandom_range(NUM_LEVELS, 1);
            enq_pct   = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            for (k = 0; k < phase_len; k++) begin
                if ($urandom_range(99) < 3) begin
                    kind = KIND_UNUSED;
                end else if ($urandom_range(99) < enq_pct) begin
                    kind = KIND_ENQ;
                    n_random++;
                end else begin
                    kind = ($urandom_range(99) < 70) ? KIND_DEQ : KIND_PEEK;
                    n_random++;
                end
                if ($urandom_range(99) < 8)
                    pri = PRI_NONE;
                else if (mode == 0 && $urandom_range(99) < 60)
                    pri = PRI_W'(favored);
                else
                    pri = PRI_W'($urandom_range(NUM_LEVELS, 1));
                if ($urandom_range(9) == 0)
                    item = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                else
                    item = $urandom;
                add_op(kind, item, pri, (k == 0) && (phase % 5 == 0));
            end
            phase++;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_if.valid || reply_queue.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && reply_queue.size() == 0) begin
            $display("strict_priority_multi_queue_tb: PASS");
        end else begin
            $display("strict_priority_multi_queue_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/spmq_pkg.sv
rtl/core/spmq_if.sv
rtl/core/spmq_store.sv
rtl/core/spmq_ctrl.sv
rtl/core/strict_priority_multi_queue.sv
sim/strict_priority_multi_queue_tb.sv
